// File: hw/rtl/packet_block_rule_check_assert.svh
// Assertion macros for the packet block rule check.
// Included by the top level; the macros expand to nothing under SYNTHESIS.
`ifndef PACKET_BLOCK_RULE_CHECK_ASSERT_SVH
`define PACKET_BLOCK_RULE_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define PBRC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("pbrc assertion failed");
`define PBRC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pbrc assertion failed");
`else
`define PBRC_ASSERT(lbl, clk, rst_n, prop)
`define PBRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/pbrc_pkg.sv
// Shared types and constants for the packet block rule check.
// Used by pbrc_cam and packet_block_rule_check; depends on nothing.
package pbrc_pkg;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned PORT_W   = 16;
	localparam int unsigned APP_W    = 5;
	localparam int unsigned REASON_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CHECK       = 3'd0,
		CMD_ADD_ADDR    = 3'd1,
		CMD_REMOVE_ADDR = 3'd2,
		CMD_ADD_PORT    = 3'd3,
		CMD_REMOVE_PORT = 3'd4,
		CMD_ADD_APP     = 3'd5,
		CMD_REMOVE_APP  = 3'd6,
		CMD_CLEAR       = 3'd7
	} cmd_t;

	typedef enum logic [REASON_W-1:0] {
		REASON_PASS = 2'd0,
		REASON_ADDR = 2'd1,
		REASON_PORT = 2'd2,
		REASON_APP  = 2'd3
	} reason_t;

	typedef struct packed {
		logic add;
		logic remove;
		logic clear;
	} cam_op_t;

	typedef struct packed {
		logic hit;
		logic full;
	} cam_stat_t;

endpackage

// File: hw/rtl/pbrc_cam.sv
// Key table with valid marks, compared against one key in all entries at once.
// Depends on pbrc_pkg for the operation and status structs.
module pbrc_cam #(
	parameter int unsigned Depth = 64,
	parameter int unsigned KeyW  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  pbrc_pkg::cam_op_t   op,
	input  logic [KeyW-1:0]     key,
	output pbrc_pkg::cam_stat_t stat
);

	logic [KeyW-1:0]  key_q [Depth];
	logic [Depth-1:0] valid_q;
	logic [Depth-1:0] match;
	logic [Depth-1:0] free;
	logic [Depth-1:0] free_first;
	logic             insert;

	for (genvar i = 0; i < Depth; i++) begin : g_entry
		assign match[i] = valid_q[i] && (key_q[i] == key);

		always_ff @(posedge clk) begin
			if (en && insert && free_first[i]) begin
				key_q[i] <= key;
			end
		end
	end

	// The lowest free entry is isolated as a one-hot vector.
	assign free       = ~valid_q;
	assign free_first = free & (~free + Depth'(1));

	assign stat.hit  = |match;
	assign stat.full = &valid_q;
	assign insert    = op.add && !stat.hit && !stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			if (op.clear) begin
				valid_q <= '0;
			end else if (insert) begin
				valid_q <= valid_q | free_first;
			end else if (op.remove) begin
				valid_q <= valid_q & ~match;
			end
		end
	end

endmodule

// File: hw/rtl/packet_block_rule_check.sv
// Top level of the packet block rule check: request register, tables and result register.
// Depends on pbrc_pkg, pbrc_cam and packet_block_rule_check_assert.svh.
//
// Each request carries a command with an address, a port and an application code.
// Commands add or remove a blocked address, port or application, clear all lists,
// or check a packet against the lists. Every request produces exactly one response
// with block_reason (pass, address, port or application) and status (set when an
// add found its table full and was dropped).
// Both channels use valid and ready. A request is registered on acceptance, and its
// response is registered from the request register once the response register is
// empty or being taken. The tables are compared in all entries at once, so one
// request is accepted in every cycle while the response side keeps taking results.
// When rsp_ready is low the response is held, and the request register holds one
// more request before req_ready drops.
// Reset clears all valid marks, the application bitmap and both valid flags; the
// block accepts requests from the first cycle after reset.
`include "packet_block_rule_check_assert.svh"

module packet_block_rule_check #(
	parameter int unsigned ADDRESS_ENTRIES = 64,
	parameter int unsigned PORT_ENTRIES    = 32,
	parameter int unsigned APP_KINDS       = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [pbrc_pkg::CMD_W-1:0]      command,
	input  logic [pbrc_pkg::ADDR_W-1:0]     address,
	input  logic [pbrc_pkg::PORT_W-1:0]     port_number,
	input  logic [pbrc_pkg::APP_W-1:0]      app_code,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [pbrc_pkg::REASON_W-1:0]   block_reason,
	output logic                            status
);

	logic                          valid_s1;
	pbrc_pkg::cmd_t                cmd_s1;
	logic [pbrc_pkg::ADDR_W-1:0]   address_s1;
	logic [pbrc_pkg::PORT_W-1:0]   port_s1;
	logic [pbrc_pkg::APP_W-1:0]    app_s1;

	logic                          rsp_valid_q;
	pbrc_pkg::reason_t             block_reason_q;
	logic                          status_q;

	logic                          advance;
	pbrc_pkg::cam_op_t             addr_op;
	pbrc_pkg::cam_op_t             port_op;
	pbrc_pkg::cam_stat_t           addr_stat;
	pbrc_pkg::cam_stat_t           port_stat;
	logic [APP_KINDS-1:0]          app_blocked_q;
	logic [APP_KINDS-1:0]          app_sel;
	logic                          app_hit;
	pbrc_pkg::reason_t             reason_d;
	logic                          status_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1     <= pbrc_pkg::cmd_t'(command);
			address_s1 <= address;
			port_s1    <= port_number;
			app_s1     <= app_code;
		end
	end

	pbrc_cam #(
		.Depth (ADDRESS_ENTRIES),
		.KeyW  (pbrc_pkg::ADDR_W)
	) u_addr_cam (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (addr_op),
		.key    (address_s1),
		.stat   (addr_stat)
	);

	pbrc_cam #(
		.Depth (PORT_ENTRIES),
		.KeyW  (pbrc_pkg::PORT_W)
	) u_port_cam (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.op     (port_op),
		.key    (port_s1),
		.stat   (port_stat)
	);

	// Application codes at or beyond APP_KINDS select no bit at all.
	for (genvar k = 0; k < APP_KINDS; k++) begin : g_app
		assign app_sel[k] = (7'(app_s1) == 7'(k));
	end
	assign app_hit = |(app_blocked_q & app_sel);

	always_comb begin
		addr_op  = '0;
		port_op  = '0;
		reason_d = pbrc_pkg::REASON_PASS;
		status_d = 1'b0;
		case (cmd_s1)
			pbrc_pkg::CMD_CHECK: begin
				if (addr_stat.hit) begin
					reason_d = pbrc_pkg::REASON_ADDR;
				end else if (port_stat.hit) begin
					reason_d = pbrc_pkg::REASON_PORT;
				end else if (app_hit) begin
					reason_d = pbrc_pkg::REASON_APP;
				end
			end
			pbrc_pkg::CMD_ADD_ADDR: begin
				addr_op.add = 1'b1;
				status_d    = !addr_stat.hit && addr_stat.full;
			end
			pbrc_pkg::CMD_REMOVE_ADDR: begin
				addr_op.remove = 1'b1;
			end
			pbrc_pkg::CMD_ADD_PORT: begin
				port_op.add = 1'b1;
				status_d    = !port_stat.hit && port_stat.full;
			end
			pbrc_pkg::CMD_REMOVE_PORT: begin
				port_op.remove = 1'b1;
			end
			pbrc_pkg::CMD_CLEAR: begin
				addr_op.clear = 1'b1;
				port_op.clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_blocked_q <= '0;
		end else if (advance) begin
			case (cmd_s1)
				pbrc_pkg::CMD_ADD_APP: begin
					app_blocked_q <= app_blocked_q | app_sel;
				end
				pbrc_pkg::CMD_REMOVE_APP: begin
					app_blocked_q <= app_blocked_q & ~app_sel;
				end
				pbrc_pkg::CMD_CLEAR: begin
					app_blocked_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			block_reason_q <= reason_d;
			status_q       <= status_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign block_reason = block_reason_q;
	assign status       = status_q;

	`PBRC_ASSERT(a_full_only_on_add, clk, arst_n, rsp_valid_q && status_q |-> block_reason_q == pbrc_pkg::REASON_PASS)
	`PBRC_ASSERT(a_stall_only_when_held, clk, arst_n, !req_ready |-> valid_s1 && rsp_valid_q && !rsp_ready)
	`PBRC_ASSERT(a_clear_empties, clk, arst_n, advance && cmd_s1 == pbrc_pkg::CMD_CLEAR |=> !addr_stat.hit && !port_stat.hit && !addr_stat.full && !port_stat.full && !app_hit)
	`PBRC_ASSERT_ALWAYS(a_reset_no_rsp, clk, !arst_n |=> !rsp_valid_q)

endmodule
